### rtl/mexp_pkg.sv
`default_nettype none

package mexp_pkg;

    // configuration register index width and register map
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_EXPONENT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS  = 2'd1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SCAN,
        ST_SQUARE,
        ST_MULT,
        ST_NEXT,
        ST_DONE
    } mexp_state_t;

endpackage

`default_nettype wire

### rtl/mexp_modmul.sv
`default_nettype none

// bit-serial interleaved modular multiplier: one bit of a per cycle, MSB first
module mexp_modmul
    import mexp_pkg::*;
#(
    parameter int WORD_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [WORD_BITS-1:0] a,
    input  wire logic [WORD_BITS-1:0] b,
    input  wire logic [WORD_BITS-1:0] m,
    output logic                      done,
    output logic [WORD_BITS-1:0]      result
);

    localparam int CW = $clog2(WORD_BITS + 1);

    // control
    logic          active_reg, active_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // operands and partial remainder
    logic [WORD_BITS-1:0] a_reg, a_next;
    logic [WORD_BITS-1:0] b_reg, b_next;
    logic [WORD_BITS-1:0] m_reg, m_next;
    logic [WORD_BITS-1:0] r_reg, r_next;

    // one step: t = 2r + bit*b stays below 3m, so subtract m or 2m
    logic [WORD_BITS+1:0] t_sum;
    logic [WORD_BITS+1:0] m_one;
    logic [WORD_BITS+1:0] m_two;
    logic [WORD_BITS+1:0] t_red;

    always_comb
    begin
        m_one = {2'b00, m_reg};
        m_two = {1'b0, m_reg, 1'b0};
        t_sum = {1'b0, r_reg, 1'b0}
              + (a_reg[WORD_BITS-1] ? {2'b00, b_reg} : '0);
        if (t_sum >= m_two)
        begin
            t_red = t_sum - m_two;
        end
        else if (t_sum >= m_one)
        begin
            t_red = t_sum - m_one;
        end
        else
        begin
            t_red = t_sum;
        end
    end

    // step control and operand shifting
    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        m_next      = m_reg;
        r_next      = r_reg;
        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = CW'(WORD_BITS);
            a_next      = a;
            b_next      = b;
            m_next      = m;
            r_next      = '0;
        end
        else if (active_reg)
        begin
            r_next   = t_red[WORD_BITS-1:0];
            a_next   = {a_reg[WORD_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        m_reg <= m_next;
        r_reg <= r_next;
    end

    assign done   = done_reg;
    assign result = r_reg;

    // checks
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !active_reg)
        else $error("multiplier started while a product is in progress");

    a_rem_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (r_reg < m_reg))
        else $error("partial remainder not below modulus");

endmodule

`default_nettype wire

### rtl/modular_exponentiation.sv
// Modular exponentiation, base^exponent mod modulus, by left-to-right
// square-and-multiply. Pulse start with base_value while busy is low; one
// result appears on power_result for exactly one cycle with done high, and
// must be taken then, as the block cannot be held off. Exponent and modulus
// are to be written through the cfg port (index 0 exponent, 1 modulus) while
// the block is idle, which the block itself does not enforce; both are
// captured when an item starts. All products go through one bit-serial
// modular multiplier: the base is first reduced, then the exponent bits are
// scanned from the top, and below the leading one every bit costs a square
// and every set bit a multiply as well. A modulus below two gives zero in the
// cycle after start.
`default_nettype none

module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int WORD_BITS = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [WORD_BITS-1:0]      base_value,
    output logic                           done,
    output logic [WORD_BITS-1:0]           power_result,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [WORD_BITS-1:0]      cfg_data
);

    localparam int CW = $clog2(WORD_BITS + 1);

    mexp_state_t state_reg, state_next;

    logic [WORD_BITS-1:0] exponent_reg;
    logic [WORD_BITS-1:0] modulus_reg;

    logic          started_reg, started_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [WORD_BITS-1:0] exp_reg, exp_next;
    logic [WORD_BITS-1:0] m_reg, m_next;
    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [WORD_BITS-1:0] bred_reg, bred_next;
    logic [WORD_BITS-1:0] result_reg, result_next;

    logic                 mul_start;
    logic [WORD_BITS-1:0] mul_a;
    logic [WORD_BITS-1:0] mul_b;
    logic [WORD_BITS-1:0] mul_m;
    logic                 mul_done;
    logic [WORD_BITS-1:0] mul_result;

    logic accept;
    logic mod_small;
    logic exp_bit;

    assign accept    = start && (state_reg == ST_IDLE);
    assign mod_small = (modulus_reg < WORD_BITS'(2));
    assign exp_bit   = exp_reg[WORD_BITS-1];

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg <= WORD_BITS'(1);
            modulus_reg  <= WORD_BITS'(65535);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_EXPONENT: exponent_reg <= cfg_data;
                REG_MODULUS:  modulus_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !mod_small)
                begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (mul_done)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                state_next = started_reg ? ST_SQUARE : ST_NEXT;
            end
            ST_SQUARE:
            begin
                if (mul_done)
                begin
                    state_next = exp_bit ? ST_MULT : ST_NEXT;
                end
            end
            ST_MULT:
            begin
                if (mul_done)
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                state_next = (cnt_reg == CW'(1)) ? ST_DONE : ST_SCAN;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and multiplier control
    always_comb
    begin
        started_next = started_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        exp_next     = exp_reg;
        m_next       = m_reg;
        acc_next     = acc_reg;
        bred_next    = bred_reg;
        result_next  = result_reg;
        mul_start    = 1'b0;
        mul_a        = acc_reg;
        mul_b        = acc_reg;
        mul_m        = m_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mod_small)
                    begin
                        result_next = '0;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        // reduce the base: base * 1 mod m
                        mul_start    = 1'b1;
                        mul_a        = base_value;
                        mul_b        = WORD_BITS'(1);
                        mul_m        = modulus_reg;
                        m_next       = modulus_reg;
                        exp_next     = exponent_reg;
                        cnt_next     = CW'(WORD_BITS);
                        started_next = 1'b0;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (mul_done)
                begin
                    bred_next = mul_result;
                end
            end
            ST_SCAN:
            begin
                if (started_reg)
                begin
                    mul_start = 1'b1;
                end
                else if (exp_bit)
                begin
                    // leading one: 1 squared times base is just the base
                    acc_next     = bred_reg;
                    started_next = 1'b1;
                end
            end
            ST_SQUARE:
            begin
                if (mul_done)
                begin
                    acc_next = mul_result;
                    if (exp_bit)
                    begin
                        mul_start = 1'b1;
                        mul_a     = mul_result;
                        mul_b     = bred_reg;
                    end
                end
            end
            ST_MULT:
            begin
                if (mul_done)
                begin
                    acc_next = mul_result;
                end
            end
            ST_NEXT:
            begin
                exp_next = {exp_reg[WORD_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - CW'(1);
            end
            ST_DONE:
            begin
                // zero exponent leaves 1, below any modulus of two or more
                result_next = started_reg ? acc_reg : WORD_BITS'(1);
                done_next   = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            started_reg <= started_next;
            done_reg    <= done_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg    <= exp_next;
        m_reg      <= m_next;
        acc_reg    <= acc_next;
        bred_reg   <= bred_next;
        result_reg <= result_next;
    end

    // shared bit-serial multiplier
    mexp_modmul #(
        .WORD_BITS (WORD_BITS)
    ) u_modmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .m      (mul_m),
        .done   (mul_done),
        .result (mul_result)
    );

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign power_result = result_reg;

    // checks
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result strobe while sequencer still working");

    a_acc_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
        (started_reg && (state_reg == ST_DONE)) |-> (acc_reg < m_reg))
        else $error("accumulator not reduced at end of item");

endmodule

`default_nettype wire

### sim/modular_exponentiation_test.sv
`timescale 1ns / 100ps

module modular_exponentiation_test;

    import mexp_pkg::*;

    localparam int WORD_BITS   = 16;
    localparam int ITEM_TARGET = 450;
    // run limit, with room for the slowest items, sender gaps and register writes
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 700;
    localparam int PRINT_CAP   = 20;

    // indexes outside the register map, writes there must change nothing
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 2'd3;

    typedef enum logic [1:0] {
        OP_ITEM,
        OP_WRITE,
        OP_DRAIN
    } op_kind_t;

    typedef struct {
        op_kind_t                  kind;
        logic [CFG_INDEX_BITS-1:0] index;
        logic [WORD_BITS-1:0]      data;
        int unsigned               gap;
    } sender_op_t;

    logic                      clk        = 1'b0;
    logic                      rst_n      = 1'b0;
    logic                      start      = 1'b0;
    logic                      busy;
    logic [WORD_BITS-1:0]      base_value = '0;
    logic                      done;
    logic [WORD_BITS-1:0]      power_result;
    logic                      cfg_valid  = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index  = REG_EXPONENT;
    logic [WORD_BITS-1:0]      cfg_data   = '0;

    // key registers as the block should hold them
    logic [WORD_BITS-1:0] key_exponent = 16'd1;
    logic [WORD_BITS-1:0] key_modulus  = 16'hFFFF;

    sender_op_t           pending_ops[$];
    sender_op_t           cur_op;
    logic                 op_loaded    = 1'b0;
    int unsigned          gap_left     = 0;
    logic [WORD_BITS-1:0] pending_powers[$];
    int unsigned          items_sent   = 0;
    int unsigned          results_seen = 0;
    int unsigned          items_queued = 0;
    int unsigned          error_count  = 0;
    int unsigned          cycle_count  = 0;
    logic                 no_gaps      = 1'b0;

    modular_exponentiation #(
        .WORD_BITS(WORD_BITS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .base_value  (base_value),
        .done        (done),
        .power_result(power_result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    // base^power mod modulus, left-to-right square and multiply
    function automatic logic [WORD_BITS-1:0] mod_power(
        input logic [WORD_BITS-1:0] base,
        input logic [WORD_BITS-1:0] power,
        input logic [WORD_BITS-1:0] modulus
    );
        logic [2*WORD_BITS-1:0] acc;
        logic [2*WORD_BITS-1:0] reduced_base;
        logic [2*WORD_BITS-1:0] wide_modulus;
        if (modulus < WORD_BITS'(2))
            return '0;
        wide_modulus = {{WORD_BITS{1'b0}}, modulus};
        reduced_base = {{WORD_BITS{1'b0}}, base} % wide_modulus;
        acc = (2*WORD_BITS)'(1);
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            acc = (acc * acc) % wide_modulus;
            if (power[i])
                acc = (acc * reduced_base) % wide_modulus;
        end
        return acc[WORD_BITS-1:0];
    endfunction

    task automatic report_error(input string msg);
        if (error_count < PRINT_CAP)
            $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic queue_item(input logic [WORD_BITS-1:0] base);
        sender_op_t op;
        op.kind  = OP_ITEM;
        op.index = REG_EXPONENT;
        op.data  = base;
        op.gap   = no_gaps ? 0 : $urandom_range(0, 7);
        pending_ops.push_back(op);
        items_queued++;
    endtask

    task automatic queue_write(input logic [CFG_INDEX_BITS-1:0] index,
                               input logic [WORD_BITS-1:0] data);
        sender_op_t op;
        op.kind  = OP_WRITE;
        op.index = index;
        op.data  = data;
        op.gap   = no_gaps ? 0 : $urandom_range(0, 7);
        pending_ops.push_back(op);
    endtask

    task automatic queue_drain();
        sender_op_t op;
        op.kind  = OP_DRAIN;
        op.index = REG_EXPONENT;
        op.data  = '0;
        op.gap   = 0;
        pending_ops.push_back(op);
    endtask

    // reset once at the start
    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // sender: items on start/busy, register writes on the cfg channel
    always @(posedge clk or negedge rst_n)
    begin : sender
        logic        next_start;
        logic        next_cfg;
        int unsigned sent_now;
        if (!rst_n)
        begin
            start        <= 1'b0;
            base_value   <= '0;
            cfg_valid    <= 1'b0;
            cfg_index    <= REG_EXPONENT;
            cfg_data     <= '0;
            items_sent   <= 0;
            op_loaded    = 1'b0;
            gap_left     = 0;
            key_exponent = 16'd1;
            key_modulus  = 16'hFFFF;
        end
        else
        begin
            next_start = start;
            next_cfg   = cfg_valid;
            sent_now   = items_sent;
            // item taken, keys as captured at start
            if (start && !busy)
            begin
                pending_powers.push_back(mod_power(base_value, key_exponent, key_modulus));
                sent_now++;
                next_start = 1'b0;
            end
            // register write taken
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_EXPONENT)
                    key_exponent = cfg_data;
                else if (cfg_index == REG_MODULUS)
                    key_modulus = cfg_data;
                next_cfg = 1'b0;
            end
            // fetch and issue the next operation
            if (!next_start && !next_cfg)
            begin
                if (!op_loaded && pending_ops.size() != 0)
                begin
                    cur_op    = pending_ops.pop_front();
                    op_loaded = 1'b1;
                    gap_left  = cur_op.gap;
                end
                if (op_loaded)
                begin
                    if (gap_left != 0)
                        gap_left--;
                    else
                    begin
                        case (cur_op.kind)
                            OP_ITEM:
                            begin
                                next_start = 1'b1;
                                base_value <= cur_op.data;
                                op_loaded  = 1'b0;
                            end
                            OP_WRITE:
                            begin
                                // keys change only with nothing in flight
                                if (results_seen == sent_now && !busy)
                                begin
                                    next_cfg  = 1'b1;
                                    cfg_index <= cur_op.index;
                                    cfg_data  <= cur_op.data;
                                    op_loaded = 1'b0;
                                end
                            end
                            default:
                            begin
                                if (results_seen == sent_now)
                                    op_loaded = 1'b0;
                            end
                        endcase
                    end
                end
            end
            start      <= next_start;
            cfg_valid  <= next_cfg;
            items_sent <= sent_now;
        end
    end

    // receiver: every done strobe is checked against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : receiver
        logic [WORD_BITS-1:0] want;
        if (!rst_n)
            results_seen <= 0;
        else if (done === 1'b1)
        begin
            if (pending_powers.size() == 0)
                report_error($sformatf("result %h with no item outstanding", power_result));
            else
            begin
                want = pending_powers.pop_front();
                if (power_result !== want)
                    report_error($sformatf("power_result got %h expected %h",
                                           power_result, want));
            end
            results_seen <= results_seen + 1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("ERROR: timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin : stimulus
        logic [WORD_BITS-1:0] phase_modulus;
        logic [WORD_BITS-1:0] phase_exponent;
        logic [WORD_BITS-1:0] b;
        int unsigned          phase_len;

        // reset keys: exponent one, modulus all ones, base not below modulus
        queue_item(16'h0000);
        queue_item(16'hFFFF);
        queue_item(16'h3039);
        // zero exponent, also with zero base
        queue_write(REG_EXPONENT, 16'h0000);
        queue_item(16'h0000);
        queue_item(16'hFFFF);
        // modulus below two
        queue_write(REG_MODULUS, 16'h0000);
        queue_item(16'h0005);
        queue_write(REG_MODULUS, 16'h0001);
        queue_item(16'hFFFF);
        // writes outside the register map are dropped
        queue_write(REG_SPARE_A, 16'hFFFF);
        queue_write(REG_SPARE_B, 16'h5555);
        queue_item(16'h0007);
        // largest exponent with a large prime modulus
        queue_write(REG_EXPONENT, 16'hFFFF);
        queue_write(REG_MODULUS, 16'd65521);
        queue_item(16'h0002);
        queue_item(16'hFFFF);
        queue_item(16'd65520);
        queue_drain();
        // smallest useful modulus
        queue_write(REG_MODULUS, 16'd2);
        queue_write(REG_EXPONENT, 16'd3);
        queue_item(16'h0003);
        queue_item(16'h0002);
        // small key pair: encrypt then decrypt
        queue_write(REG_MODULUS, 16'd3233);
        queue_write(REG_EXPONENT, 16'd17);
        queue_item(16'd65);
        queue_write(REG_EXPONENT, 16'd2753);
        queue_item(16'd2790);
        // single top exponent bit, alternating base patterns
        queue_write(REG_MODULUS, 16'hFFFF);
        queue_write(REG_EXPONENT, 16'h8000);
        queue_item(16'hAAAA);
        queue_item(16'h5555);

        // random phases, each under its own key
        while (items_queued < ITEM_TARGET)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 7))
                0:       phase_modulus = WORD_BITS'($urandom_range(0, 1));
                1:       phase_modulus = WORD_BITS'($urandom_range(2, 255));
                2:       phase_modulus = 16'hFFFF;
                default: phase_modulus = WORD_BITS'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 7))
                0:       phase_exponent = '0;
                1:       phase_exponent = 16'hFFFF;
                2:       phase_exponent = WORD_BITS'($urandom_range(1, 31));
                default: phase_exponent = WORD_BITS'($urandom_range(0, 65535));
            endcase
            queue_write(REG_MODULUS, phase_modulus);
            queue_write(REG_EXPONENT, phase_exponent);
            if ($urandom_range(0, 7) == 0)
                queue_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                            WORD_BITS'($urandom_range(0, 65535)));
            phase_len = $urandom_range(8, 30);
            for (int n = 0; n < phase_len; n++)
            begin
                if (n == phase_len / 2 && $urandom_range(0, 1) == 1)
                    queue_drain();
                case ($urandom_range(0, 9))
                    0:       b = '0;
                    1:       b = 16'hFFFF;
                    2, 3:
                    begin
                        if (phase_modulus > WORD_BITS'(1))
                            b = WORD_BITS'($urandom_range(0,
                                    phase_modulus - WORD_BITS'(1)));
                        else
                            b = WORD_BITS'($urandom_range(0, 65535));
                    end
                    default: b = WORD_BITS'($urandom_range(0, 65535));
                endcase
                queue_item(b);
            end
        end

        // let everything drain, then watch for stray results
        while (pending_ops.size() != 0 || op_loaded || start || cfg_valid)
            @(posedge clk);
        while (results_seen != items_sent)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_powers.size() != 0)
            report_error($sformatf("%0d items never produced a result",
                                   pending_powers.size()));

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
